// ----- hdl/spic_pkg.sv -----
`timescale 1ns / 1ps

package spic_pkg;

	// Operation codes of an input word.
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_RESP  = 2'd2;

	// Dense register numbers.
	localparam logic [4:0] REG_VERID = 5'd0;
	localparam logic [4:0] REG_PARAM = 5'd1;
	localparam logic [4:0] REG_CR    = 5'd2;
	localparam logic [4:0] REG_SR    = 5'd3;
	localparam logic [4:0] REG_IER   = 5'd4;
	localparam logic [4:0] REG_DER   = 5'd5;
	localparam logic [4:0] REG_CFGR0 = 5'd6;
	localparam logic [4:0] REG_CFGR1 = 5'd7;
	localparam logic [4:0] REG_DMR0  = 5'd8;
	localparam logic [4:0] REG_DMR1  = 5'd9;
	localparam logic [4:0] REG_CCR   = 5'd10;
	localparam logic [4:0] REG_CCR1  = 5'd11;
	localparam logic [4:0] REG_FCR   = 5'd12;
	localparam logic [4:0] REG_FSR   = 5'd13;
	localparam logic [4:0] REG_TCR   = 5'd14;
	localparam logic [4:0] REG_TDR   = 5'd15;
	localparam logic [4:0] REG_RSR   = 5'd16;
	localparam logic [4:0] REG_RDR   = 5'd17;
	localparam logic [4:0] REG_RDROR = 5'd18;

	localparam logic [31:0] VERID_VALUE = 32'h0200_0004;
	localparam logic [15:0] PARAM_LOW   = 16'h0202;
	localparam logic [31:0] TCR_RESET   = 32'h0000_001F;

	// Positions of the write-1-to-clear flags within the stored flag field (SR bits 13:8).
	localparam int FLAG_WCF = 0;
	localparam int FLAG_FCF = 1;
	localparam int FLAG_TCF = 2;
	localparam int FLAG_TEF = 3;
	localparam int FLAG_REF = 4;
	localparam int FLAG_DMF = 5;

	// TCR bit positions.
	localparam int TCR_TXMSK = 18;
	localparam int TCR_RXMSK = 19;
	localparam int TCR_CONT  = 21;
	localparam int TCR_LSBF  = 23;

	// Control register write bits.
	localparam int CR_MEN   = 0;
	localparam int CR_RST   = 1;
	localparam int CR_DBGEN = 3;
	localparam int CR_RTF   = 8;
	localparam int CR_RRF   = 9;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  reg_index;
		logic [31:0] write_data;
		logic [31:0] spi_rx_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        spi_tx_valid;
		logic [31:0] spi_tx_word;
		logic [5:0]  spi_frame_bits;
	} result_t;

endpackage

// ----- hdl/spi_controller_fifo_regs.sv -----
`timescale 1ns / 1ps

// Register-mapped SPI master with transmit and receive FIFOs.
//
// Each input word (a bus read, a bus write, or the SPI response for the
// outstanding frame) is taken at a rising edge with start high and busy low.
// Busy is always low, so a word can be issued in every cycle. The word is
// captured in an input register and processed in the following cycle, where
// all register, FIFO and flag updates are made in one pass. The result word
// appears on result for exactly one cycle, marked by done, after passing
// through the input register and the result register. Throughput is one word
// per cycle, set by the single update pass between those registers.
//
// A result carries the read value, the interrupt level after the word, and
// a launched frame when one is started. The receiver cannot stall, so every
// result must be taken in the cycle that done is high.
//
// The chip-select count register is written with cfg_we and cfg_data while the
// block is idle, which the user must ensure; the block does not enforce it. Reset
// clears all control state, empties both FIFOs and leaves TCR at its reset value.
module spi_controller_fifo_regs #(
	parameter int FIFO_DEPTH     = 4,
	parameter int MAX_FRAME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spic_pkg::in_item_t item,
	output logic               done,
	output spic_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_data
);
	import spic_pkg::*;

	localparam int LW = $clog2(FIFO_DEPTH + 1);
	localparam int IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = (LW > 2) ? LW : 2;

	// Input stage.
	logic     vld_s1;
	in_item_t item_s1;

	// Result stage.
	logic    done_s2;
	result_t res_s2;

	// Architectural state.
	logic [3:0]    cs_cnt_q;
	logic [2:0]    ctrl_q;
	logic [5:0]    w1c_q;
	logic [31:0]   ier_q, der_q, cfgr0_q, cfgr1_q, dmr0_q, dmr1_q, ccr_q, ccr1_q, fcr_q;
	logic [31:0]   tcr_q;
	logic [31:0]   last_q;
	logic          sof_q, await_q, sent_q;
	logic [LW-1:0] tx_lvl_q, rx_lvl_q;
	logic [31:0]   tx_q [FIFO_DEPTH];
	logic [31:0]   rx_q [FIFO_DEPTH];

	// Next state.
	logic [2:0]    ctrl_d;
	logic [5:0]    w1c_d;
	logic [31:0]   ier_d, der_d, cfgr0_d, cfgr1_d, dmr0_d, dmr1_d, ccr_d, ccr1_d, fcr_d;
	logic [31:0]   tcr_d;
	logic [31:0]   last_d;
	logic          sof_d, await_d, sent_d;
	logic [LW-1:0] tx_lvl_d, rx_lvl_d;
	logic [31:0]   tx_d [FIFO_DEPTH];
	logic [31:0]   rx_d [FIFO_DEPTH];

	logic [31:0] rd_data;
	logic        launch, men_rise, rst_rise, stop;
	logic [31:0] rx_word, head, masked, reversed, frame_word;
	logic        irq_d;

	// Frame size from TCR, capped.
	logic [12:0] fsz;
	logic [5:0]  frame_bits;
	logic [31:0] frame_mask;
	logic        tdf_q, rdf_q, tdf_d, rdf_d;
	logic [31:0] sr_value;

	assign busy = 1'b0;
	assign done = done_s2;
	assign result = res_s2;

	assign fsz = {1'b0, tcr_q[11:0]} + 13'd1;
	assign frame_bits = (fsz > 13'(MAX_FRAME_BITS)) ? 6'(MAX_FRAME_BITS) : fsz[5:0];
	assign frame_mask = 32'hFFFF_FFFF >> (6'd32 - frame_bits);

	// Computed watermark flags of the current state.
	assign tdf_q = CW'(tx_lvl_q) <= CW'(fcr_q[1:0]);
	assign rdf_q = CW'(rx_lvl_q) > CW'(fcr_q[17:16]);
	assign sr_value = {18'd0, w1c_q, 6'd0, rdf_q, tdf_q};

	always_comb begin
		tx_d = tx_q;
		rx_d = rx_q;
		tx_lvl_d = tx_lvl_q;
		rx_lvl_d = rx_lvl_q;
		ctrl_d = ctrl_q;
		w1c_d = w1c_q;
		ier_d = ier_q;
		der_d = der_q;
		cfgr0_d = cfgr0_q;
		cfgr1_d = cfgr1_q;
		dmr0_d = dmr0_q;
		dmr1_d = dmr1_q;
		ccr_d = ccr_q;
		ccr1_d = ccr1_q;
		fcr_d = fcr_q;
		tcr_d = tcr_q;
		last_d = last_q;
		sof_d = sof_q;
		await_d = await_q;
		sent_d = sent_q;
		rd_data = '0;
		launch = 1'b0;
		men_rise = 1'b0;
		rst_rise = 1'b0;
		stop = 1'b0;
		rx_word = item_s1.spi_rx_word & frame_mask;
		head = '0;
		masked = '0;
		reversed = '0;
		frame_word = '0;

		if (vld_s1) begin
			unique case (item_s1.operation)
				OP_READ: begin
					unique case (item_s1.reg_index)
						REG_VERID: rd_data = VERID_VALUE;
						REG_PARAM: rd_data = {12'd0, cs_cnt_q, PARAM_LOW};
						REG_CR:    rd_data = {28'd0, ctrl_q[2], 1'b0, ctrl_q[1:0]};
						REG_SR:    rd_data = sr_value;
						REG_IER:   rd_data = ier_q;
						REG_DER:   rd_data = der_q;
						REG_CFGR0: rd_data = cfgr0_q;
						REG_CFGR1: rd_data = cfgr1_q;
						REG_DMR0:  rd_data = dmr0_q;
						REG_DMR1:  rd_data = dmr1_q;
						REG_CCR:   rd_data = ccr_q;
						REG_CCR1:  rd_data = ccr1_q;
						REG_FCR:   rd_data = fcr_q;
						REG_FSR:   rd_data = (32'(rx_lvl_q) << 16) | 32'(tx_lvl_q);
						REG_TCR:   rd_data = tcr_q;
						REG_RSR:   rd_data = {30'd0, rx_lvl_q == '0, sof_q};
						REG_RDR: begin
							if (rx_lvl_q == '0) begin
								rd_data = last_q;
							end else begin
								rd_data = rx_q[0];
								last_d = rx_q[0];
								for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
									rx_d[i] = rx_q[i + 1];
								end
								rx_lvl_d = rx_lvl_q - LW'(1);
								sof_d = (rx_lvl_q == LW'(1));
							end
						end
						REG_RDROR: rd_data = last_q;
						default:   rd_data = '0;
					endcase
				end
				OP_WRITE: begin
					unique case (item_s1.reg_index)
						REG_CR: begin
							men_rise = !ctrl_q[CR_MEN] && item_s1.write_data[CR_MEN];
							rst_rise = !ctrl_q[CR_RST] && item_s1.write_data[CR_RST];
							if (item_s1.write_data[CR_RTF]) begin
								tx_lvl_d = '0;
							end
							if (item_s1.write_data[CR_RRF]) begin
								rx_lvl_d = '0;
								sof_d = 1'b1;
							end
							ctrl_d = {item_s1.write_data[CR_DBGEN], item_s1.write_data[1:0]};
							if (rst_rise) begin
								w1c_d = '0;
								ier_d = '0;
								der_d = '0;
								cfgr0_d = '0;
								cfgr1_d = '0;
								dmr0_d = '0;
								dmr1_d = '0;
								ccr_d = '0;
								ccr1_d = '0;
								fcr_d = '0;
								tcr_d = TCR_RESET;
								last_d = '0;
								tx_lvl_d = '0;
								rx_lvl_d = '0;
								sof_d = 1'b1;
								await_d = 1'b0;
								sent_d = 1'b0;
							end
							if (men_rise && ctrl_d[CR_MEN] && cfgr1_d[0] && !await_d) begin
								if (tx_lvl_d != '0) begin
									launch = 1'b1;
								end else begin
									w1c_d[FLAG_TEF] = 1'b1;
								end
							end
						end
						REG_SR:    w1c_d = w1c_q & ~item_s1.write_data[13:8];
						REG_IER:   ier_d = item_s1.write_data;
						REG_DER:   der_d = item_s1.write_data;
						REG_CFGR0: cfgr0_d = item_s1.write_data;
						REG_CFGR1: cfgr1_d = item_s1.write_data;
						REG_DMR0:  dmr0_d = item_s1.write_data;
						REG_DMR1:  dmr1_d = item_s1.write_data;
						REG_CCR:   ccr_d = item_s1.write_data;
						REG_CCR1:  ccr1_d = item_s1.write_data;
						REG_FCR:   fcr_d = item_s1.write_data;
						REG_TCR:   tcr_d = item_s1.write_data;
						REG_TDR: begin
							if (tx_lvl_q < LW'(FIFO_DEPTH)) begin
								tx_d[tx_lvl_q[IW-1:0]] = item_s1.write_data;
								tx_lvl_d = tx_lvl_q + LW'(1);
								if (!await_q && ctrl_q[CR_MEN] && cfgr1_q[0]) begin
									launch = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
				OP_RESP: begin
					if (await_q) begin
						await_d = 1'b0;
						if (!tcr_q[TCR_RXMSK]) begin
							if (rx_lvl_q >= LW'(FIFO_DEPTH)) begin
								w1c_d[FLAG_REF] = 1'b1;
								stop = 1'b1;
							end else begin
								rx_d[rx_lvl_q[IW-1:0]] = rx_word;
								rx_lvl_d = rx_lvl_q + LW'(1);
								if ((cfgr1_q[18:16] != 3'd0) && (rx_word == dmr0_q)) begin
									w1c_d[FLAG_DMF] = 1'b1;
								end
							end
						end
						if (!stop && (tx_lvl_q != '0) && ctrl_q[CR_MEN] && cfgr1_q[0]) begin
							launch = 1'b1;
						end else begin
							if (sent_q) begin
								w1c_d[FLAG_WCF] = 1'b1;
								if ((tx_lvl_q == '0) && !tcr_q[TCR_CONT]) begin
									w1c_d[FLAG_FCF] = 1'b1;
									w1c_d[FLAG_TCF] = 1'b1;
								end
							end
							sent_d = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end

		// Launch the head of the transmit queue.
		if (launch) begin
			head = tx_d[0];
			for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
				tx_d[i] = tx_d[i + 1];
			end
			tx_lvl_d = tx_lvl_d - LW'(1);
			await_d = 1'b1;
			sent_d = 1'b1;
		end
		masked = head & frame_mask;
		for (int i = 0; i < 32; i++) begin
			reversed[i] = masked[31 - i];
		end
		if (!launch || tcr_q[TCR_TXMSK]) begin
			frame_word = '0;
		end else if (tcr_q[TCR_LSBF]) begin
			frame_word = reversed >> (6'd32 - frame_bits);
		end else begin
			frame_word = masked;
		end

		// Interrupt level after this word.
		tdf_d = CW'(tx_lvl_d) <= CW'(fcr_d[1:0]);
		rdf_d = CW'(rx_lvl_d) > CW'(fcr_d[17:16]);
		irq_d = (|(ier_d[13:8] & w1c_d)) || (ier_d[0] && tdf_d) || (ier_d[1] && rdf_d);
	end

	// FIFO storage holds data only; the levels say what is valid.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			tx_q <= tx_d;
			rx_q <= rx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_s1 <= item;
		end
		if (vld_s1) begin
			res_s2.read_data <= rd_data;
			res_s2.irq_level <= irq_d;
			res_s2.spi_tx_valid <= launch;
			res_s2.spi_tx_word <= frame_word;
			res_s2.spi_frame_bits <= launch ? frame_bits : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_s2 <= 1'b0;
			cs_cnt_q <= 4'd4;
			ctrl_q <= '0;
			w1c_q <= '0;
			ier_q <= '0;
			der_q <= '0;
			cfgr0_q <= '0;
			cfgr1_q <= '0;
			dmr0_q <= '0;
			dmr1_q <= '0;
			ccr_q <= '0;
			ccr1_q <= '0;
			fcr_q <= '0;
			tcr_q <= TCR_RESET;
			last_q <= '0;
			sof_q <= 1'b1;
			await_q <= 1'b0;
			sent_q <= 1'b0;
			tx_lvl_q <= '0;
			rx_lvl_q <= '0;
		end else begin
			vld_s1 <= start;
			done_s2 <= vld_s1;
			if (cfg_we) begin
				cs_cnt_q <= cfg_data;
			end
			if (vld_s1) begin
				ctrl_q <= ctrl_d;
				w1c_q <= w1c_d;
				ier_q <= ier_d;
				der_q <= der_d;
				cfgr0_q <= cfgr0_d;
				cfgr1_q <= cfgr1_d;
				dmr0_q <= dmr0_d;
				dmr1_q <= dmr1_d;
				ccr_q <= ccr_d;
				ccr1_q <= ccr1_d;
				fcr_q <= fcr_d;
				tcr_q <= tcr_d;
				last_q <= last_d;
				sof_q <= sof_d;
				await_q <= await_d;
				sent_q <= sent_d;
				tx_lvl_q <= tx_lvl_d;
				rx_lvl_q <= rx_lvl_d;
			end
		end
	end

	// The FIFO levels never pass the depth.
	a_tx_level: assert property (@(posedge clk) disable iff (!arst_n)
		tx_lvl_q <= LW'(FIFO_DEPTH))
		else $error("transmit level above depth");

	a_rx_level: assert property (@(posedge clk) disable iff (!arst_n)
		rx_lvl_q <= LW'(FIFO_DEPTH))
		else $error("receive level above depth");

	// A launched frame leaves a response outstanding and has a nonzero size.
	a_launch_await: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 && res_s2.spi_tx_valid |-> await_q && (res_s2.spi_frame_bits != 6'd0))
		else $error("frame launched without an outstanding response");

	// Without a launch the frame fields are zero.
	a_idle_frame: assert property (@(posedge clk) disable iff (!arst_n)
		done_s2 && !res_s2.spi_tx_valid |->
			(res_s2.spi_tx_word == '0) && (res_s2.spi_frame_bits == 6'd0))
		else $error("frame fields set without a launch");

	// A result follows each accepted word in the cycle after its capture.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done_s2)
		else $error("result missing for a captured word");

endmodule
